@@ hdl/prr_pkg.sv @@
// Shared types, constants and CRC-8 helper for the position request responder.
package prr_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CRC_POLY          = 8'h07;
   localparam logic [7:0] SYNC_VALUE_RESET  = 8'h55;
   localparam logic [7:0] POS_REQ_RESET     = 8'h50;

   localparam logic [7:0] CSR_SYNC_VALUE    = 8'd0;
   localparam logic [7:0] CSR_POS_REQ_CODE  = 8'd1;

   // response byte slots
   localparam logic [2:0] SLOT_SYNC   = 3'd0;
   localparam logic [2:0] SLOT_POS_HI = 3'd1;
   localparam logic [2:0] SLOT_POS_LO = 3'd2;
   localparam logic [2:0] SLOT_STATUS = 3'd3;
   localparam logic [2:0] SLOT_CRC    = 3'd4;

   typedef enum logic [2:0] {
      PHASE_SYNC  = 3'b001,
      PHASE_CMD   = 3'b010,
      PHASE_CHECK = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [15:0] encoder_position;
      logic [7:0]  motor_status;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]  sync_value;
      logic [15:0] position;
      logic [7:0]  status;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ hdl/prr_front.sv @@
// Request parser: configuration registers, sync/command/check phases, job issue.
module prr_front
   import prr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [7:0]       csr_wdata,
   input  queue_status_type q_status,
   output logic             q_push,
   output job_type          q_job
);

   logic [7:0] sync_value_ff, sync_value_in;
   logic [7:0] pos_req_ff, pos_req_in;
   logic [7:0] held_cmd_ff, held_cmd_in;
   phase_type  phase_ff, phase_in;
   logic       req_accept;
   logic       check_ok;

   assign csr_ready  = 1'b1;
   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   assign check_ok = (crc8_add(8'h00, held_cmd_ff) == req_payload.rx_byte) &&
                     (held_cmd_ff == pos_req_ff);

   always_comb begin
      sync_value_in = sync_value_ff;
      pos_req_in    = pos_req_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYNC_VALUE:   sync_value_in = csr_wdata;
            CSR_POS_REQ_CODE: pos_req_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      held_cmd_in = held_cmd_ff;
      q_push      = 1'b0;
      if (req_accept) begin
         case (phase_ff)
            PHASE_CMD: begin
               held_cmd_in = req_payload.rx_byte;
               phase_in    = PHASE_CHECK;
            end
            PHASE_CHECK: begin
               phase_in = PHASE_SYNC;
               q_push   = check_ok;
            end
            default: begin
               phase_in = (req_payload.rx_byte == sync_value_ff) ? PHASE_CMD : PHASE_SYNC;
            end
         endcase
      end
   end

   assign q_job.sync_value = sync_value_ff;
   assign q_job.position   = req_payload.encoder_position;
   assign q_job.status     = req_payload.motor_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff <= SYNC_VALUE_RESET;
         pos_req_ff    <= POS_REQ_RESET;
         held_cmd_ff   <= 8'h00;
         phase_ff      <= PHASE_SYNC;
      end else begin
         sync_value_ff <= sync_value_in;
         pos_req_ff    <= pos_req_in;
         held_cmd_ff   <= held_cmd_in;
         phase_ff      <= phase_in;
      end
   end

endmodule

@@ hdl/prr_queue.sv @@
// Short job queue between parser and response sender.
module prr_queue
   import prr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_job         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.not_empty)
      else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");
`endif

endmodule

@@ hdl/prr_back.sv @@
// Response sender: five bytes per job with running CRC-8, registered output.
module prr_back
   import prr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          q_job,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_payload_type  rsp_payload
);

   logic            busy_ff, busy_in;
   logic [2:0]      slot_ff, slot_in;
   job_type         job_ff, job_in;
   logic [7:0]      crc_ff, crc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            load_ok;
   logic            emit;
   logic            finishing;
   logic [7:0]      cur_byte;

   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && load_ok;
   assign finishing = emit && (slot_ff == SLOT_CRC);
   assign q_pop     = q_status.not_empty && (!busy_ff || finishing);

   always_comb begin
      case (slot_ff)
         SLOT_SYNC:   cur_byte = job_ff.sync_value;
         SLOT_POS_HI: cur_byte = job_ff.position[15:8];
         SLOT_POS_LO: cur_byte = job_ff.position[7:0];
         SLOT_STATUS: cur_byte = job_ff.status;
         default:     cur_byte = crc_ff;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      job_in       = job_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.tx_byte    = cur_byte;
         rsp_in.last_byte  = (slot_ff == SLOT_CRC);
         slot_in           = slot_ff + 1'b1;
         if (slot_ff == SLOT_SYNC) begin
            crc_in = 8'h00;
         end else if (slot_ff != SLOT_CRC) begin
            crc_in = crc8_add(crc_ff, cur_byte);
         end
         if (finishing) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in = 1'b1;
         slot_in = SLOT_SYNC;
         job_in  = q_job;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      crc_ff <= crc_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= SLOT_SYNC;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!busy_ff || slot_ff == SLOT_CRC))
      else $error("job taken while a response is in progress");
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (slot_ff <= SLOT_CRC))
      else $error("slot counter out of range");
   a_last_on_crc: assert property (@(posedge clock) disable iff (reset)
      finishing |=> (rsp_valid_ff && rsp_ff.last_byte))
      else $error("CRC byte not flagged last");
   a_last_only_crc: assert property (@(posedge clock) disable iff (reset)
      (emit && slot_ff != SLOT_CRC) |=> !rsp_ff.last_byte)
      else $error("last flag on a non-CRC byte");
`endif

endmodule

@@ hdl/position_request_responder_core.sv @@
// Top level of the position request responder: parser, job queue and response sender.
// Takes one received byte per cycle while req_stall is low. After sync, a command byte
// and a matching CRC-8 check byte for the position request command, it answers with
// five bytes (sync, position high, position low, motor state, CRC-8 of the middle
// three), last_byte set on the CRC byte. Position and state are those sampled with the
// check byte. The response sender puts out one byte per cycle while not stalled, through
// a registered output; up to two further answered requests wait in the job queue, and
// req_stall rises only while that queue is full. Each job passes the queue and the
// sender's job register before it is sent. Configuration: index 0 sync value, index 1
// request code; other indexes are ignored; csr_ready is always high.
module position_request_responder_core
   import prr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_index,
   input  logic [7:0]      csr_wdata
);

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   job_type          push_job;
   job_type          head_job;

   prr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   prr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   prr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_job       (head_job),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
